[hw/rtl/binned_depth_window_centroid_macros.svh]
// Assertion macros used by the binned depth window centroid top level.
`ifndef BINNED_DEPTH_WINDOW_CENTROID_MACROS_SVH
`define BINNED_DEPTH_WINDOW_CENTROID_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDWC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BDWC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/bdwc_pkg.sv]
// Package with constants, codes and controller/datapath interface types.
`default_nettype none
package bdwc_pkg;

   localparam int NUM_CHROMS_DEF     = 32;
   localparam int BINS_PER_CHROM_DEF = 65536;

   localparam int BS_W     = 21;
   localparam int MUL_W    = BS_W + 8;
   localparam int CENT_W   = 44;
   localparam int DIV_STEPS = 31;

   localparam logic [BS_W-1:0] BIN_WIDTH_RESET = 21'd100;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_COUNT = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NEG   = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_ZERO  = 2'd3;

   typedef struct packed {
      logic       accept;
      logic       div_step;
      logic       sum_init;
      logic       sum_step;
      logic       mul_init;
      logic       mul_step;
      logic       qdiv_init;
      logic       qdiv_step;
      logic       out_load;
      logic [1:0] out_status;
   } cmd_type;

   typedef struct packed {
      logic neg_bound;
      logic range_err;
      logic empty_win;
      logic sum_last;
      logic pipe_busy;
      logic total_zero;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

[hw/rtl/bdwc_ctl.sv]
// Controller state machine sequencing loads and window queries.
`default_nettype none
module bdwc_ctl
   import bdwc_pkg::*;
#(
   parameter int BINS_PER_CHROM = BINS_PER_CHROM_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic [1:0] req_op,
   output logic            req_stall,
   output cmd_type         cmd,
   input  wire sts_type    sts
);

   localparam int IDX_W  = $clog2(BINS_PER_CHROM);
   localparam int WSUM_W = 16 + 2 * IDX_W;
   localparam int N_W    = WSUM_W + MUL_W;
   localparam int STEP_W = $clog2(N_W + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_QSTART, S_DIV, S_CHECK, S_SUM, S_DRAIN, S_MUL, S_QDIV, S_FIN
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        code_ff, code_in;
   logic              step_done;

   assign step_done = (step_ff == '0);
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.accept     = req_valid && (state_ff == S_IDLE);
      cmd.out_status = code_ff;
      state_in       = state_ff;
      step_in        = step_ff;
      code_in        = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (cmd.accept && req_op == OP_QUERY) begin
               state_in = S_QSTART;
            end
         end
         S_QSTART: begin
            if (sts.neg_bound) begin
               code_in  = ST_NEG;
               state_in = S_FIN;
            end else begin
               step_in  = STEP_W'(DIV_STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.range_err) begin
               code_in  = ST_RANGE;
               state_in = S_FIN;
            end else if (sts.empty_win) begin
               code_in  = ST_ZERO;
               state_in = S_FIN;
            end else begin
               cmd.sum_init = 1'b1;
               state_in     = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (sts.sum_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               if (sts.total_zero) begin
                  code_in  = ST_ZERO;
                  state_in = S_FIN;
               end else begin
                  cmd.mul_init = 1'b1;
                  step_in      = STEP_W'(MUL_W - 1);
                  state_in     = S_MUL;
               end
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            step_in      = step_ff - 1'b1;
            if (step_done) begin
               cmd.qdiv_init = 1'b1;
               step_in       = STEP_W'(N_W - 1);
               state_in      = S_QDIV;
            end
         end
         S_QDIV: begin
            cmd.qdiv_step = 1'b1;
            step_in       = step_ff - 1'b1;
            if (step_done) begin
               code_in  = ST_OK;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         code_ff  <= code_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/bdwc_dp.sv]
// Datapath: depth and count stores, dividers, window accumulator and output register.
`default_nettype none
module bdwc_dp
   import bdwc_pkg::*;
#(
   parameter int NUM_CHROMS     = NUM_CHROMS_DEF,
   parameter int BINS_PER_CHROM = BINS_PER_CHROM_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [1:0]         req_op,
   input  wire logic [4:0]         req_chrom,
   input  wire logic [15:0]        req_bin_index,
   input  wire logic [15:0]        req_depth_value,
   input  wire logic [16:0]        req_bin_count,
   input  wire logic [31:0]        req_window_start,
   input  wire logic [31:0]        req_window_end,
   input  wire logic               csr_wr_en,
   input  wire logic [BS_W-1:0]    csr_wr_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [CENT_W-1:0]       rsp_centroid_q8
);

   localparam int IDX_W  = $clog2(BINS_PER_CHROM);
   localparam int CNT_W  = $clog2(BINS_PER_CHROM + 1);
   localparam int CH_W   = (NUM_CHROMS > 1) ? $clog2(NUM_CHROMS) : 1;
   localparam int TOT_W  = 16 + IDX_W;
   localparam int PROD_W = 16 + IDX_W;
   localparam int WSUM_W = 16 + 2 * IDX_W;
   localparam int N_W    = WSUM_W + MUL_W;
   localparam longint unsigned MEM_DEPTH = longint'(NUM_CHROMS) * longint'(BINS_PER_CHROM);
   localparam int ADDR_W = $clog2(MEM_DEPTH);

   logic [15:0]       depth_mem [MEM_DEPTH];
   logic [CNT_W-1:0]  cnt_mem [NUM_CHROMS];
   logic [NUM_CHROMS-1:0] cnt_vld_ff;

   logic [BS_W-1:0]   bin_width_ff;
   logic [BS_W-1:0]   bs_eff;

   logic [4:0]        chrom_ff;
   logic              neg_ff;
   logic [CNT_W-1:0]  cnt_rd_ff;
   logic              cnt_vld_rd_ff;
   logic [30:0]       dq_s_ff, dq_e_ff;
   logic [BS_W-1:0]   rem_s_ff, rem_e_ff;

   logic [IDX_W-1:0]  idx_ff;
   logic              v1_ff, v2_ff;
   logic [15:0]       rd_data_ff, d2_ff;
   logic [IDX_W-1:0]  idx1_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [TOT_W-1:0]  total_ff;
   logic [WSUM_W-1:0] wsum_ff;

   logic [N_W-1:0]    n_ff, mcand_ff;
   logic [MUL_W-1:0]  mplier_ff;
   logic [TOT_W-1:0]  rem_ff;

   logic [CENT_W-1:0] cent_ff;
   logic [1:0]        status_ff;
   logic              rsp_valid_ff;

   logic              wr_ok, cnt_ok, is_query;
   logic [CNT_W-1:0]  cnt_sat, cnt_eff;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [TOT_W:0]    rem_sh;
   logic              q_ge;

   // One restoring-division step: returns {remainder, quotient} after shifting in one bit.
   function automatic logic [BS_W+30:0] div_step_f(input logic [BS_W-1:0] rem,
                                                    input logic [30:0] dq,
                                                    input logic [BS_W-1:0] dsr);
      logic [BS_W:0] sh;
      logic          ge;
      sh = {rem, dq[30]};
      ge = (sh >= {1'b0, dsr});
      if (ge) begin
         sh = sh - {1'b0, dsr};
      end
      return {sh[BS_W-1:0], dq[29:0], ge};
   endfunction

   assign bs_eff   = (bin_width_ff == '0) ? BS_W'(1) : bin_width_ff;
   assign is_query = cmd.accept && (req_op == OP_QUERY);
   assign wr_ok    = (32'(req_chrom) < NUM_CHROMS) && (32'(req_bin_index) < BINS_PER_CHROM);
   assign cnt_ok   = (32'(req_chrom) < NUM_CHROMS);
   assign cnt_sat  = (32'(req_bin_count) > BINS_PER_CHROM) ? CNT_W'(BINS_PER_CHROM)
                                                          : CNT_W'(req_bin_count);
   assign wr_addr  = ADDR_W'(req_chrom) * ADDR_W'(BINS_PER_CHROM) + ADDR_W'(req_bin_index);
   assign rd_addr  = ADDR_W'(chrom_ff) * ADDR_W'(BINS_PER_CHROM) + ADDR_W'(idx_ff);
   assign cnt_eff  = cnt_vld_rd_ff ? cnt_rd_ff : '0;

   assign rem_sh   = {rem_ff, n_ff[N_W-1]};
   assign q_ge     = (rem_sh >= (TOT_W+1)'(total_ff));

   assign sts.neg_bound  = neg_ff;
   assign sts.range_err  = !(32'(chrom_ff) < NUM_CHROMS)
                           || (32'(dq_s_ff) >= 32'(cnt_eff))
                           || (32'(dq_e_ff) >= 32'(cnt_eff));
   assign sts.empty_win  = (dq_s_ff >= dq_e_ff);
   assign sts.sum_last   = ((32'(idx_ff) + 32'd1) == 32'(dq_e_ff));
   assign sts.pipe_busy  = v1_ff || v2_ff;
   assign sts.total_zero = (total_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_centroid_q8 = cent_ff;

   // Stores: one write port each, registered reads.
   always_ff @(posedge clock) begin
      if (cmd.accept && req_op == OP_WRITE && wr_ok) begin
         depth_mem[wr_addr] <= req_depth_value;
      end
      if (cmd.sum_step) begin
         rd_data_ff <= depth_mem[rd_addr];
      end
      if (cmd.accept && req_op == OP_COUNT && cnt_ok) begin
         cnt_mem[CH_W'(req_chrom)] <= cnt_sat;
      end
      if (is_query) begin
         cnt_rd_ff     <= cnt_mem[CH_W'(req_chrom)];
         cnt_vld_rd_ff <= cnt_vld_ff[CH_W'(req_chrom)];
      end
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff   <= '0;
         bin_width_ff <= BIN_WIDTH_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept && req_op == OP_COUNT && cnt_ok) begin
            cnt_vld_ff[CH_W'(req_chrom)] <= 1'b1;
         end
         if (csr_wr_en) begin
            bin_width_ff <= csr_wr_data;
         end
         v1_ff <= cmd.sum_step;
         v2_ff <= v1_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (is_query) begin
         chrom_ff <= req_chrom;
         neg_ff   <= req_window_start[31] || req_window_end[31];
         dq_s_ff  <= req_window_start[30:0];
         dq_e_ff  <= req_window_end[30:0];
         rem_s_ff <= '0;
         rem_e_ff <= '0;
      end else if (cmd.div_step) begin
         {rem_s_ff, dq_s_ff} <= div_step_f(rem_s_ff, dq_s_ff, bs_eff);
         {rem_e_ff, dq_e_ff} <= div_step_f(rem_e_ff, dq_e_ff, bs_eff);
      end

      if (cmd.sum_init) begin
         idx_ff   <= IDX_W'(dq_s_ff);
         total_ff <= '0;
         wsum_ff  <= '0;
      end else begin
         if (cmd.sum_step) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (v2_ff) begin
            total_ff <= total_ff + TOT_W'(d2_ff);
            wsum_ff  <= wsum_ff + WSUM_W'(prod_ff);
         end
      end
      idx1_ff <= idx_ff;
      if (v1_ff) begin
         prod_ff <= idx1_ff * rd_data_ff;
         d2_ff   <= rd_data_ff;
      end

      if (cmd.mul_init) begin
         n_ff      <= '0;
         mcand_ff  <= N_W'(wsum_ff);
         mplier_ff <= {bs_eff, 8'd0};
      end else if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            n_ff <= n_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[N_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[MUL_W-1:1]};
      end else if (cmd.qdiv_step) begin
         rem_ff <= q_ge ? TOT_W'(rem_sh - (TOT_W+1)'(total_ff)) : TOT_W'(rem_sh);
         n_ff   <= {n_ff[N_W-2:0], q_ge};
      end
      if (cmd.qdiv_init) begin
         rem_ff <= '0;
      end

      if (cmd.out_load) begin
         status_ff <= cmd.out_status;
         cent_ff   <= (cmd.out_status == ST_OK) ? n_ff[CENT_W-1:0] : '0;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/binned_depth_window_centroid.sv]
// Top level of the binned depth window centroid block.
// A depth write or bin count write returns no word. A full query runs the sign check, the two
// index divisions, the bin count check, the window walk, the drain of the read pipeline, then
// the serial multiply and division. Refused or empty queries answer after the sign check, the
// divisions or the drain. One word at a time; the next is taken the cycle after the answer loads.
// Reset: synchronous, active high; clears bin counts and control state, bin width set to 100.
`default_nettype none
`include "binned_depth_window_centroid_macros.svh"
module binned_depth_window_centroid
   import bdwc_pkg::*;
#(
   parameter int NUM_CHROMS     = NUM_CHROMS_DEF,
   parameter int BINS_PER_CHROM = BINS_PER_CHROM_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_op,
   input  wire logic [4:0]         req_chrom,
   input  wire logic [15:0]        req_bin_index,
   input  wire logic [15:0]        req_depth_value,
   input  wire logic [16:0]        req_bin_count,
   input  wire logic signed [31:0] req_window_start,
   input  wire logic signed [31:0] req_window_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_status,
   output logic [CENT_W-1:0]       rsp_centroid_q8,
   input  wire logic               csr_wr_en,
   input  wire logic [BS_W-1:0]    csr_wr_data
);

   // The controller sequences each query: sign check, the two index divisions run
   // side by side, the bin count check, the walk over the window with one depth read
   // per cycle, and finally the scaled division that yields the centroid in Q8.
   cmd_type cmd;
   sts_type sts;

   bdwc_ctl #(
      .BINS_PER_CHROM(BINS_PER_CHROM)
   ) u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds both stores, the dividers, the accumulators and the output
   // register, which keeps a finished word until the receiving side takes it.
   bdwc_dp #(
      .NUM_CHROMS    (NUM_CHROMS),
      .BINS_PER_CHROM(BINS_PER_CHROM)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_op           (req_op),
      .req_chrom        (req_chrom),
      .req_bin_index    (req_bin_index),
      .req_depth_value  (req_depth_value),
      .req_bin_count    (req_bin_count),
      .req_window_start (req_window_start),
      .req_window_end   (req_window_end),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_centroid_q8  (rsp_centroid_q8)
   );

   // A non-zero status always carries a zero centroid.
   `BDWC_ASSERT_SAME(a_cent_zero, clock, reset, rsp_valid && (rsp_status != ST_OK), rsp_centroid_q8 == '0, "centroid not zero on error status")
   // A new word never overwrites one that is still stalled at the output.
   `BDWC_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.out_load, !(rsp_valid && rsp_stall), "output overwritten while stalled")
   // While the window walk or the final division runs, no new word is taken in.
   `BDWC_ASSERT_SAME(a_busy_stall, clock, reset, cmd.sum_step || cmd.qdiv_step, req_stall, "input taken during a query")
   // Loading the output always produces a valid word in the next cycle.
   `BDWC_ASSERT_NEXT(a_load_valid, clock, reset, cmd.out_load, rsp_valid, "loaded word not valid")

endmodule
`default_nettype wire

[test/binned_depth_window_centroid_test.sv]
// Self-checking testbench for the binned depth window centroid block.
`timescale 1ns / 1ps
module binned_depth_window_centroid_test;
   import bdwc_pkg::*;

   // One request word as it travels on the req_ channel.
   typedef struct {
      logic [1:0]         op;
      logic [4:0]         chrom;
      logic [15:0]        bin_index;
      logic [15:0]        depth_value;
      logic [16:0]        bin_count;
      logic signed [31:0] window_start;
      logic signed [31:0] window_end;
   } depth_req_type;

   // One answer word as it leaves on the rsp_ channel.
   typedef struct {
      logic [1:0]        status;
      logic [CENT_W-1:0] centroid;
   } centroid_rsp_type;

   localparam int          CHROM_COUNT = 32;
   localparam int          CHROM_BINS  = 65536;
   localparam int          CYCLE_LIMIT = 3000000;
   localparam int          DRAIN_WAIT  = 400;
   localparam logic [63:0] POS_MAX     = 64'h7FFF_FFFF;
   // The one operation code that the block ignores.
   localparam logic [1:0]  OP_SKIP     = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_op = OP_WRITE;
   logic [4:0]              req_chrom = '0;
   logic [15:0]             req_bin_index = '0;
   logic [15:0]             req_depth_value = '0;
   logic [16:0]             req_bin_count = '0;
   logic signed [31:0]      req_window_start = '0;
   logic signed [31:0]      req_window_end = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [1:0]              rsp_status;
   logic [CENT_W-1:0]       rsp_centroid_q8;
   logic                    csr_wr_en = 1'b0;
   logic [BS_W-1:0]         csr_wr_data = '0;

   // Shadow copy of the block's state, kept in step with every accepted word.
   logic [15:0]             depth_shadow [int];
   logic [16:0]             count_shadow [CHROM_COUNT];
   logic [BS_W-1:0]         bin_width_shadow;

   centroid_rsp_type        pending_centroids [$];
   int                      error_count = 0;
   int                      words_sent = 0;
   int                      cycle_count = 0;
   // While set, neither side inserts gaps or stalls.
   bit                      no_idle = 1'b0;

   binned_depth_window_centroid dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_chrom        (req_chrom),
      .req_bin_index    (req_bin_index),
      .req_depth_value  (req_depth_value),
      .req_bin_count    (req_bin_count),
      .req_window_start (req_window_start),
      .req_window_end   (req_window_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_centroid_q8  (rsp_centroid_q8),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a run that hangs is a failed run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic int depth_key(logic [4:0] chrom, logic [15:0] idx);
      return int'({chrom, idx});
   endfunction

   function automatic logic [63:0] effective_bin_width();
      return (bin_width_shadow == 0) ? 64'd1 : 64'(bin_width_shadow);
   endfunction

   // Works out the answer to a window query from the shadow state. The
   // fractional part of the mean is scaled before the divide; r * m stays
   // below 2^61, so plain 64-bit arithmetic is exact here.
   function automatic centroid_rsp_type predict_centroid(depth_req_type w);
      logic [63:0]      bs;
      logic [63:0]      s_idx;
      logic [63:0]      e_idx;
      logic [63:0]      total;
      logic [63:0]      wsum;
      logic [63:0]      m;
      logic [63:0]      a;
      logic [63:0]      r;
      logic [63:0]      q;
      centroid_rsp_type res;
      res.status   = ST_OK;
      res.centroid = '0;
      total        = 0;
      wsum         = 0;
      if (w.window_start[31] || w.window_end[31]) begin
         res.status = ST_NEG;
         return res;
      end
      bs    = effective_bin_width();
      s_idx = 64'(unsigned'(w.window_start)) / bs;
      e_idx = 64'(unsigned'(w.window_end)) / bs;
      if (e_idx >= count_shadow[w.chrom] || s_idx >= count_shadow[w.chrom]) begin
         res.status = ST_RANGE;
         return res;
      end
      for (logic [63:0] idx = s_idx; idx < e_idx; idx++) begin
         total += 64'(depth_shadow[depth_key(w.chrom, idx[15:0])]);
         wsum  += idx * 64'(depth_shadow[depth_key(w.chrom, idx[15:0])]);
      end
      if (total == 0) begin
         res.status = ST_ZERO;
         return res;
      end
      m = bs << 8;
      a = wsum / total;
      r = wsum % total;
      q = a * m + (r * m) / total;
      res.centroid = q[CENT_W-1:0];
      return res;
   endfunction

   // Applies an accepted word to the shadow state and records what it must answer.
   task automatic absorb_word(depth_req_type w);
      case (w.op)
         OP_WRITE: begin
            depth_shadow[depth_key(w.chrom, w.bin_index)] = w.depth_value;
         end
         OP_COUNT: begin
            count_shadow[w.chrom] = (w.bin_count > CHROM_BINS) ? 17'(CHROM_BINS) : w.bin_count;
         end
         OP_QUERY: begin
            pending_centroids.push_back(predict_centroid(w));
         end
         default: begin
         end
      endcase
   endtask

   // Sends one word, with an occasional gap first, and waits for it to be taken.
   task automatic send_word(depth_req_type w);
      if (!no_idle && $urandom_range(0, 99) < 10) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_op           <= w.op;
      req_chrom        <= w.chrom;
      req_bin_index    <= w.bin_index;
      req_depth_value  <= w.depth_value;
      req_bin_count    <= w.bin_count;
      req_window_start <= w.window_start;
      req_window_end   <= w.window_end;
      do
         @(posedge clock);
      while (req_stall);
      absorb_word(w);
      if (w.op != OP_SKIP)
         words_sent++;
   endtask

   function automatic depth_req_type blank_word(logic [1:0] op, logic [4:0] chrom);
      depth_req_type w;
      w.op           = op;
      w.chrom        = chrom;
      w.bin_index    = 16'($urandom);
      w.depth_value  = 16'($urandom);
      w.bin_count    = 17'($urandom);
      w.window_start = $urandom;
      w.window_end   = $urandom;
      return w;
   endfunction

   task automatic send_depth(logic [4:0] chrom, logic [15:0] idx, logic [15:0] depth);
      depth_req_type w;
      w             = blank_word(OP_WRITE, chrom);
      w.bin_index   = idx;
      w.depth_value = depth;
      send_word(w);
   endtask

   task automatic send_count(logic [4:0] chrom, logic [16:0] cnt);
      depth_req_type w;
      w           = blank_word(OP_COUNT, chrom);
      w.bin_count = cnt;
      send_word(w);
   endtask

   // Sends a window query. Bins that the window would read but that were never
   // written get a depth first, so the block never reads an undefined entry.
   // A window that would read too many bins is collapsed to an empty one.
   task automatic send_query(logic [4:0] chrom, logic signed [31:0] ws,
                             logic signed [31:0] we);
      depth_req_type w;
      logic [63:0]   s_idx;
      logic [63:0]   e_idx;
      logic [15:0]   depth;
      w = blank_word(OP_QUERY, chrom);
      if (!ws[31] && !we[31]) begin
         s_idx = 64'(unsigned'(ws)) / effective_bin_width();
         e_idx = 64'(unsigned'(we)) / effective_bin_width();
         if (s_idx < count_shadow[chrom] && e_idx < count_shadow[chrom] && s_idx < e_idx) begin
            if (e_idx - s_idx > 48) begin
               we = ws;
            end else begin
               for (logic [63:0] idx = s_idx; idx < e_idx; idx++) begin
                  if (!depth_shadow.exists(depth_key(chrom, idx[15:0]))) begin
                     depth = ($urandom_range(0, 99) < 12) ? 16'd0 : 16'($urandom);
                     send_depth(chrom, idx[15:0], depth);
                  end
               end
            end
         end
      end
      w.window_start = ws;
      w.window_end   = we;
      send_word(w);
   endtask

   // Builds a window that lies inside the chromosome's bins, raising the bin
   // count first when it is too small, and picks a position within each bin.
   task automatic send_inner_query();
      logic [63:0] bs;
      logic [63:0] max_idx;
      logic [63:0] len;
      logic [63:0] s_i;
      logic [63:0] e_i;
      logic [63:0] ws;
      logic [63:0] we;
      logic [4:0]  chrom;
      bs      = effective_bin_width();
      max_idx = POS_MAX / bs;
      if (max_idx > CHROM_BINS - 2)
         max_idx = CHROM_BINS - 2;
      chrom = 5'($urandom);
      len   = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 12) : $urandom_range(13, 40);
      if (len > max_idx)
         len = max_idx;
      e_i = ($urandom_range(0, 99) < 10) ? max_idx : $urandom_range(len, max_idx);
      s_i = e_i - len;
      if (count_shadow[chrom] <= e_i)
         send_count(chrom, 17'($urandom_range(e_i + 1, CHROM_BINS)));
      ws = s_i * bs + $urandom_range(0, (bs - 1 < POS_MAX - s_i * bs) ? bs - 1
                                                                      : POS_MAX - s_i * bs);
      we = e_i * bs + $urandom_range(0, (bs - 1 < POS_MAX - e_i * bs) ? bs - 1
                                                                      : POS_MAX - e_i * bs);
      send_query(chrom, ws[31:0], we[31:0]);
   endtask

   // Waits until every answer has come back and the block has settled, then
   // writes the bin width register.
   task automatic write_bin_width(logic [BS_W-1:0] value);
      req_valid <= 1'b0;
      wait (pending_centroids.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      bin_width_shadow = value;
   endtask

   // Answer side: random stalls, and every word taken is checked in order.
   always @(posedge clock) begin
      centroid_rsp_type exp_word;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_centroids.size() == 0) begin
            error_count++;
            $display("%0t: unexpected answer status %0d centroid %0d",
                     $time, rsp_status, rsp_centroid_q8);
         end else begin
            exp_word = pending_centroids.pop_front();
            if (rsp_status !== exp_word.status) begin
               error_count++;
               $display("%0t: status expected %0d actual %0d",
                        $time, exp_word.status, rsp_status);
            end
            if (rsp_centroid_q8 !== exp_word.centroid) begin
               error_count++;
               $display("%0t: centroid expected %0d actual %0d",
                        $time, exp_word.centroid, rsp_centroid_q8);
            end
         end
      end
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < 10);
   end

   // The state left by reset: no bins are valid and the bin width is 100.
   task automatic test_reset_state();
      send_query(5'd0, 32'sd0, 32'sd150);
      send_count(5'd3, 17'd10);
      send_query(5'd3, 32'sd100, 32'sd999);
   endtask

   // Extremes of the fields and each special case, one word at a time.
   task automatic test_corner_cases();
      depth_req_type w;
      w = blank_word(OP_SKIP, 5'd7);
      send_word(w);
      send_count(5'd31, 17'h1FFFF);
      send_depth(5'd31, 16'hFFFE, 16'hFFFF);
      send_depth(5'd31, 16'hFFFF, 16'd1);
      send_query(5'd31, 32'sd6553400, 32'sd6553599);
      send_query(5'd31, 32'sd6553400, 32'sd6553600);
      send_query(5'd31, 32'sh8000_0000, 32'sd100);
      send_query(5'd31, 32'sd100, -32'sd1);
      send_query(5'd31, 32'sd2147483647, 32'sd2147483647);
      send_count(5'd0, 17'd20);
      send_query(5'd0, 32'sd1500, 32'sd1000);
      send_query(5'd0, 32'sd1000, 32'sd2000);
      send_depth(5'd0, 16'd10, 16'd0);
      send_query(5'd0, 32'sd1000, 32'sd1150);
      send_depth(5'd0, 16'd11, 16'd0);
      send_query(5'd0, 32'sd1000, 32'sd1250);
      send_count(5'd0, 17'd0);
      send_query(5'd0, 32'sd0, 32'sd0);
      send_count(5'd0, 17'd65536);
      send_query(5'd0, 32'sd0, 32'sd1900);
   endtask

   // Random mix: mostly windows inside the written bins, the rest noise.
   task automatic test_random_mix(int words);
      int            start;
      int            pick;
      depth_req_type w;
      start = words_sent;
      while (words_sent - start < words) begin
         no_idle = (words_sent - start > words / 3) && (words_sent - start < words / 2);
         pick    = $urandom_range(0, 99);
         if (pick < 55) begin
            send_inner_query();
         end else if (pick < 72) begin
            send_depth(5'($urandom), 16'($urandom), 16'($urandom));
         end else if (pick < 80) begin
            send_count(5'($urandom), 17'($urandom));
         end else if (pick < 97) begin
            w = blank_word(OP_QUERY, 5'($urandom));
            if ($urandom_range(0, 1))
               w.window_start[31] = 1'b1;
            send_query(w.chrom, w.window_start, w.window_end);
         end else begin
            w = blank_word(OP_SKIP, 5'($urandom));
            send_word(w);
         end
      end
      no_idle = 1'b0;
   endtask

   // The bin width register at its extremes, at zero, at a random value and at its reset value.
   task automatic test_bin_widths();
      write_bin_width(21'd1);
      test_random_mix(330);
      write_bin_width(21'h10_0000);
      test_random_mix(300);
      write_bin_width(21'd0);
      test_random_mix(250);
      write_bin_width(21'h1F_FFFF);
      test_random_mix(250);
      write_bin_width(21'($urandom_range(2, 5000)));
      test_random_mix(300);
      write_bin_width(BIN_WIDTH_RESET);
      test_random_mix(300);
   endtask

   initial begin
      bin_width_shadow = BIN_WIDTH_RESET;
      foreach (count_shadow[i])
         count_shadow[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_corner_cases();
      test_bin_widths();
      req_valid <= 1'b0;
      wait (pending_centroids.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0 && pending_centroids.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
